// ===== sv/rmit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the range maximum index tree: sizes, operation and register codes,
// sequencer states and the reset image of the winner tree. No dependencies.
package rmit_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int COUNT_W      = IDX_W + 1;
    localparam int NODE_W       = IDX_W + 1;
    localparam int WALK_W       = IDX_W + 2;
    localparam int VALUE_W      = 32;
    localparam int PADDR_W      = 2;
    localparam int PDATA_W      = 32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [PADDR_W-1:0] REG_ELEMENT_COUNT = '0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    // Leftmost element (zero based) under an internal node of the heap-ordered tree.
    function automatic logic [IDX_W-1:0] leftmost_leaf(input logic [IDX_W-1:0] node);
        logic [IDX_W-1:0]   result;
        logic [2*IDX_W-1:0] wide;
        result = '0;
        for (int k = 0; k < IDX_W; k++) begin
            if (node[k]) begin
                wide   = {node, {IDX_W{1'b0}}} >> k;
                result = wide[IDX_W-1:0];
            end
        end
        return result;
    endfunction

endpackage
`default_nettype wire

// ===== sv/range_max_index_tree.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Range maximum index tree: element and winner memories with a walk sequencer.
// Depends on rmit_pkg.
//
//  Channel   Signals                                         Direction
//  request   start, busy, i_operation, i_index_lo,
//            i_index_hi, i_value                             in (busy out)
//  result    o_result_valid, o_found, o_max_index,
//            o_max_value                                     out
//  config    psel, penable, pwrite, paddr, pwdata, prdata,
//            pready                                          in/out
//
// After its request an update or a query holds busy high until its walk and reads
// are done; an empty query or an ignored update does not raise busy at all. The
// walk issues tree nodes into a read pipeline through the winner memory and the
// element memory, and a query may take two nodes per tree level. After reset a
// clearing pass holds busy high.
// A result is shown for one cycle; the receiver cannot stall.
module range_max_index_tree (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_operation,
    input  wire logic [rmit_pkg::COUNT_W-1:0]     i_index_lo,
    input  wire logic [rmit_pkg::COUNT_W-1:0]     i_index_hi,
    input  wire logic signed [rmit_pkg::VALUE_W-1:0] i_value,
    output logic                                  o_result_valid,
    output logic                                  o_found,
    output logic [rmit_pkg::COUNT_W-1:0]          o_max_index,
    output logic signed [rmit_pkg::VALUE_W-1:0]   o_max_value,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rmit_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [rmit_pkg::PDATA_W-1:0]     pwdata,
    output logic [rmit_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);
    import rmit_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_ELEMENTS);
    localparam logic [WALK_W-1:0]  LEAF_BASE = WALK_W'(MAX_ELEMENTS - 1);
    localparam logic [WALK_W-1:0]  ROOT_NODE = WALK_W'(1);

    t_state r_state, n_state;

    logic [VALUE_W-1:0] mem_val  [MAX_ELEMENTS];
    logic [IDX_W-1:0]   mem_tree [MAX_ELEMENTS];

    logic [COUNT_W-1:0] r_count;
    logic [IDX_W-1:0]   r_clr;
    logic               r_is_query;
    logic [WALK_W-1:0]  r_l, n_l;
    logic [WALK_W-1:0]  r_r, n_r;

    logic               r_p1_vld;
    logic [NODE_W-1:0]  r_p1_node;
    logic               r_p2_vld;
    logic [IDX_W-1:0]   r_p2_idx;
    logic [IDX_W-1:0]   r_p2_par;

    logic               r_acc_vld;
    logic [IDX_W-1:0]   r_acc_idx;
    logic signed [VALUE_W-1:0] r_acc_val;

    logic               r_res_vld;
    logic               r_found;
    logic [COUNT_W-1:0] r_max_index;
    logic signed [VALUE_W-1:0] r_max_value;

    logic [IDX_W-1:0]   r_tree_rd;
    logic [VALUE_W-1:0] r_val_rd;

    logic               accept;
    logic               clearing;
    logic               running;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] lo_clip;
    logic [COUNT_W-1:0] hi_clip;
    logic               q_empty;
    logic               upd_ok;
    logic [COUNT_W-1:0] upd_pos;
    logic [WALK_W-1:0]  l_inc;
    logic               walk_busy;
    logic               emit;
    logic [NODE_W-1:0]  emit_node;
    logic               run_done;
    logic [IDX_W-1:0]   p1_win;
    logic signed [VALUE_W-1:0] cand_val;
    logic               better;
    logic [IDX_W-1:0]   new_idx;
    logic signed [VALUE_W-1:0] new_val;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic               tree_we;
    logic [IDX_W-1:0]   tree_waddr;
    logic [IDX_W-1:0]   tree_wdata;
    logic               cfg_we;

    // Request decode.
    always_comb begin
        accept  = start && !busy;
        cnt     = (r_count > COUNT_MAX) ? COUNT_MAX : r_count;
        lo_clip = (i_index_lo == '0) ? COUNT_W'(1) : i_index_lo;
        hi_clip = (i_index_hi > cnt) ? cnt : i_index_hi;
        q_empty = lo_clip > hi_clip;
        upd_ok  = (i_index_lo != '0) && (i_index_lo <= cnt);
        upd_pos = COUNT_W'(i_index_lo - COUNT_W'(1));
    end

    // Node walk: an update visits the siblings of its path; a query walks the
    // covering nodes of its range from both ends toward the root.
    always_comb begin
        emit      = 1'b0;
        emit_node = '0;
        n_l       = r_l;
        n_r       = r_r;
        l_inc     = WALK_W'(r_l + WALK_W'(1));
        walk_busy = r_is_query ? (r_l <= r_r) : (r_l != ROOT_NODE);
        if (accept) begin
            if (i_operation == OP_QUERY) begin
                n_l = WALK_W'({1'b0, lo_clip} + LEAF_BASE);
                n_r = WALK_W'({1'b0, hi_clip} + LEAF_BASE);
            end else begin
                n_l = WALK_W'({1'b0, i_index_lo} + LEAF_BASE);
            end
        end else if (running && walk_busy) begin
            if (!r_is_query) begin
                emit      = 1'b1;
                emit_node = r_l[NODE_W-1:0] ^ NODE_W'(1);
                n_l       = r_l >> 1;
            end else if (r_l[0]) begin
                emit      = 1'b1;
                emit_node = r_l[NODE_W-1:0];
                n_l       = l_inc;
                if (r_r[0] || (l_inc > r_r)) begin
                    n_l = l_inc >> 1;
                    n_r = r_r >> 1;
                end
            end else if (!r_r[0]) begin
                emit      = 1'b1;
                emit_node = r_r[NODE_W-1:0];
                n_l       = r_l >> 1;
                n_r       = WALK_W'(r_r - WALK_W'(1)) >> 1;
            end else begin
                n_l = r_l >> 1;
                n_r = r_r >> 1;
            end
        end
        run_done = running && !walk_busy && !r_p1_vld && !r_p2_vld;
    end

    // Candidate compare: larger value wins, a tie goes to the lower index.
    always_comb begin
        p1_win   = r_p1_node[IDX_W] ? r_p1_node[IDX_W-1:0] : r_tree_rd;
        cand_val = $signed(r_val_rd);
        better   = !r_acc_vld || (cand_val > r_acc_val)
                   || ((cand_val == r_acc_val) && (r_p2_idx < r_acc_idx));
        new_idx  = better ? r_p2_idx : r_acc_idx;
        new_val  = better ? cand_val : r_acc_val;
    end

    // Memory write ports.
    always_comb begin
        val_we     = 1'b0;
        val_waddr  = upd_pos[IDX_W-1:0];
        val_wdata  = i_value;
        tree_we    = 1'b0;
        tree_waddr = r_p2_par;
        tree_wdata = new_idx;
        if (clearing) begin
            val_we     = 1'b1;
            val_waddr  = r_clr;
            val_wdata  = '0;
            tree_we    = 1'b1;
            tree_waddr = r_clr;
            tree_wdata = leftmost_leaf(r_clr);
        end else begin
            val_we  = accept && (i_operation == OP_UPDATE) && upd_ok;
            tree_we = r_p2_vld && !r_is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            mem_val[val_waddr] <= val_wdata;
        end
        r_val_rd <= mem_val[p1_win];
    end

    always_ff @(posedge i_clk) begin
        if (tree_we) begin
            mem_tree[tree_waddr] <= tree_wdata;
        end
        r_tree_rd <= mem_tree[emit_node[IDX_W-1:0]];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == {IDX_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && ((i_operation == OP_UPDATE) ? upd_ok : !q_empty)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        busy     = 1'b1;
        clearing = 1'b0;
        running  = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE:  busy     = 1'b0;
            ST_RUN:   running  = 1'b1;
            default:  clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_res_vld <= 1'b0;
            r_acc_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= clearing ? IDX_W'(r_clr + IDX_W'(1)) : r_clr;
            r_p1_vld  <= emit;
            r_p2_vld  <= r_p1_vld;
            r_res_vld <= (accept && (i_operation == OP_QUERY) && q_empty)
                         || (run_done && r_is_query);
            if (accept) begin
                r_acc_vld <= (i_operation == OP_UPDATE);
            end else if (r_p2_vld) begin
                r_acc_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l       <= n_l;
        r_r       <= n_r;
        r_p1_node <= emit_node;
        r_p2_idx  <= p1_win;
        r_p2_par  <= r_p1_node[NODE_W-1:1];
        if (accept) begin
            r_is_query <= (i_operation == OP_QUERY);
            r_acc_idx  <= upd_pos[IDX_W-1:0];
            r_acc_val  <= i_value;
        end else if (r_p2_vld) begin
            r_acc_idx <= new_idx;
            r_acc_val <= new_val;
        end
        if (accept) begin
            r_found     <= 1'b0;
            r_max_index <= '0;
            r_max_value <= '0;
        end else if (run_done) begin
            r_found     <= 1'b1;
            r_max_index <= COUNT_W'({1'b0, r_acc_idx} + COUNT_W'(1));
            r_max_value <= r_acc_val;
        end
    end

    // Configuration port.
    always_comb begin
        cfg_we = psel && penable && pwrite && (paddr == REG_ELEMENT_COUNT);
        pready = 1'b1;
        prdata = (paddr == REG_ELEMENT_COUNT) ? PDATA_W'(r_count) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_MAX;
        end else if (cfg_we) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_found        = r_found;
    assign o_max_index    = r_max_index;
    assign o_max_value    = r_max_value;

    // A result is only shown once the sequencer is free again.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // An empty range reports zero index and zero value.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_max_index == '0 && o_max_value == '0))
        else $error("empty result carries data");

    // A found index lies inside the element array.
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_found) |-> (o_max_index != '0 && o_max_index <= COUNT_MAX))
        else $error("found index out of range");

    // The read pipeline only carries nodes while an operation walks the tree.
    a_pipe_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_vld || r_p2_vld) |-> (r_state == ST_RUN))
        else $error("tree read outside a walk");

endmodule
`default_nettype wire
